// ===== rtl/core/cbb_pkg.sv =====
// shared types and constants for the clipped box blur
`default_nettype none
package cbb_pkg;

    // defaults for the size parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 7;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIM_W      = 11;
    localparam int RAD_CFG_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

    localparam logic [DIM_W-1:0]     IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0]     IMAGE_HEIGHT_RST = 11'd1024;
    localparam logic [RAD_CFG_W-1:0] RADIUS_RST       = 3'd1;

    // stream payload
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int OUT_POS_W  = 10;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/cbb_ram.sv =====
// generic single-clock ram with one write port and a registered read port
`default_nettype none
module cbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/clipped_box_blur_top.sv =====
// clipped box blur: streaming mean filter over rgb frames
//
// Pixels come in on the slave stream in raster order (tuser low) and are
// written into a ring of recent pixels held in one synchronous ram. Drain
// items (tuser high) flush the remaining outputs after the last pixel of a
// frame. Each accepted item gives zero or one result on the master stream:
// the per-channel truncated mean of the window of the configured radius,
// clipped at the frame borders, with its column, row and a tlast on the
// last pixel of the frame. Outputs run radius rows plus radius pixels behind.
// An item that gives a result runs the sequencer through scan, wait, divide
// and emit: one ram read per window pixel from the single read port, then a
// bit-serial division of SUM_W steps (16 at the default size). The input is
// not ready again until the result is in the output register; an item that
// gives no result leaves the block ready. The finished result waits in an
// output register, so the next item is taken while the receiver stalls; a
// second result waits in the sequencer until that register frees. Reset sets
// the registers to 1024 x 1024 with radius 1 and starts a new frame; the ram
// is not cleared. A write to one of the three registers restarts the frame.
`default_nettype none
module clipped_box_blur_top #(
    parameter int MAX_WIDTH  = cbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cbb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = cbb_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [cbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbb_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cbb_pkg::IN_DATA_W-1:0]  s_tdata,  // in_red, in_green, in_blue
    input  wire logic                           s_tuser,  // op
    // output stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cbb_pkg::OUT_DATA_W-1:0]      m_tdata,  // out_red, out_green, out_blue,
                                                          // out_col, out_row, zero pad
    output logic                                m_tlast   // frame_done
);

    localparam int COL_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
    localparam int LIN_W    = COL_W + ROW_W;
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int WIN_W    = $clog2(2 * MAX_RADIUS + 1);
    localparam int LS_DEPTH = 2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1;
    localparam int AW       = $clog2(LS_DEPTH);
    localparam int SA_W     = AW + LIN_W;
    localparam int WIN_MAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W    = $clog2(WIN_MAX + 1);
    localparam int SUM_W    = $clog2(WIN_MAX * 255 + 1);
    localparam int DIV_CW   = $clog2(SUM_W);
    localparam int CH_W     = cbb_pkg::CH_W;

    cbb_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [cbb_pkg::DIM_W-1:0]     width_reg, width_next;
    logic [cbb_pkg::DIM_W-1:0]     height_reg, height_next;
    logic [cbb_pkg::RAD_CFG_W-1:0] radius_reg, radius_next;

    // positions
    logic [LIN_W-1:0] in_lin_reg, in_lin_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic [LIN_W-1:0] out_lin_reg, out_lin_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [AW-1:0]    out_base_reg, out_base_next;

    // window scan
    logic [COL_W-1:0] oc_reg, oc_next;
    logic [ROW_W-1:0] orow_reg, orow_next;
    logic             done_reg, done_next;
    logic [WIN_W-1:0] a_reg, a_next;
    logic [WIN_W-1:0] b_reg, b_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_inb_reg, pend_inb_next;

    // sums and division
    logic [SUM_W-1:0]  sum_reg [3];
    logic [SUM_W-1:0]  sum_next [3];
    logic [CNT_W-1:0]  rem_reg [3];
    logic [CNT_W-1:0]  rem_next [3];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [cbb_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    // effective settings
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [RAD_W-1:0] r_eff;
    logic [LIN_W-1:0] total;
    logic [LIN_W-1:0] lag;
    logic [WIN_W-1:0] two_r;

    logic             acc, is_pix, emit, go, last_out, cfg_hit, scan_end, out_free;
    logic [LIN_W:0]   in_lin_inc;
    localparam int PIX_W_L = cbb_pkg::PIX_W;
    logic [PIX_W_L-1:0] rdata;

    logic signed [SA_W-1:0] start_addr, step, stepped;
    logic signed [ROW_W+1:0] j_pos;
    logic signed [COL_W+1:0] i_pos;
    logic                    inb;
    logic [CNT_W:0]          rem_t [3];
    logic [CNT_W-1:0]        divisor;

    // clamp configuration
    always_comb
    begin
        if (width_reg == '0)
            w_eff = COL_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = COL_W'(MAX_WIDTH);
        else
            w_eff = COL_W'(width_reg);
        if (height_reg == '0)
            h_eff = ROW_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = ROW_W'(MAX_HEIGHT);
        else
            h_eff = ROW_W'(height_reg);
        if (32'(radius_reg) > MAX_RADIUS)
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = RAD_W'(radius_reg);
    end

    assign total = LIN_W'(w_eff) * LIN_W'(h_eff);
    assign lag   = LIN_W'(r_eff) * LIN_W'(w_eff) + LIN_W'(r_eff);
    assign two_r = WIN_W'({r_eff, 1'b0});

    // item decode
    assign s_tready   = (state_reg == cbb_pkg::ST_IDLE);
    assign acc        = s_tvalid & s_tready;
    assign is_pix     = !s_tuser && (in_lin_reg < total);
    assign in_lin_inc = {1'b0, in_lin_reg} + 1'b1;
    assign emit       = is_pix ? (({1'b0, out_lin_reg} + {1'b0, lag}) < in_lin_inc)
                               : (in_lin_reg >= total);
    assign go         = emit && (out_lin_reg < total);
    assign last_out   = ({1'b0, out_lin_reg} + 1'b1) >= {1'b0, total};
    assign cfg_hit    = cfg_we && (cfg_index == cbb_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == cbb_pkg::REG_IMAGE_HEIGHT ||
                                   cfg_index == cbb_pkg::REG_RADIUS);
    assign scan_end   = (a_reg == two_r) && (b_reg == two_r);
    assign out_free   = !m_valid_reg || m_tready;

    // window geometry
    always_comb
    begin
        start_addr = SA_W'(out_base_reg) - SA_W'(lag);
        if (start_addr < 0)
            start_addr = start_addr + SA_W'(LS_DEPTH);
        if (b_reg == two_r)
            step = SA_W'(w_eff) - SA_W'(two_r);
        else
            step = SA_W'(1);
        stepped = SA_W'(rd_addr_reg) + step;
        if (stepped < 0)
            stepped = stepped + SA_W'(LS_DEPTH);
        else if (stepped >= SA_W'(LS_DEPTH))
            stepped = stepped - SA_W'(LS_DEPTH);
        j_pos = (ROW_W+2)'(orow_reg) + (ROW_W+2)'(a_reg) - (ROW_W+2)'(r_eff);
        i_pos = (COL_W+2)'(oc_reg) + (COL_W+2)'(b_reg) - (COL_W+2)'(r_eff);
        inb   = (j_pos >= 0) && (j_pos < (ROW_W+2)'(h_eff)) &&
                (i_pos >= 0) && (i_pos < (COL_W+2)'(w_eff));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbb_pkg::ST_IDLE:
            begin
                if (acc && go)
                    state_next = cbb_pkg::ST_SCAN;
            end
            cbb_pkg::ST_SCAN:
            begin
                if (scan_end)
                    state_next = cbb_pkg::ST_WAIT;
            end
            cbb_pkg::ST_WAIT:
            begin
                state_next = cbb_pkg::ST_DIV;
            end
            cbb_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DIV_CW'(SUM_W - 1))
                    state_next = cbb_pkg::ST_EMIT;
            end
            cbb_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = cbb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cbb_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration and positions
    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        radius_next   = radius_reg;
        in_lin_next   = in_lin_reg;
        wr_addr_next  = wr_addr_reg;
        out_lin_next  = out_lin_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_base_next = out_base_reg;
        oc_next       = oc_reg;
        orow_next     = orow_reg;
        done_next     = done_reg;
        if (cfg_hit)
        begin
            case (cfg_index)
                cbb_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                cbb_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
                cbb_pkg::REG_RADIUS:       radius_next = cfg_data[cbb_pkg::RAD_CFG_W-1:0];
                default:                   width_next  = width_reg;
            endcase
            in_lin_next   = '0;
            wr_addr_next  = '0;
            out_lin_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_base_next = '0;
        end
        else if (acc)
        begin
            if (is_pix)
            begin
                in_lin_next = in_lin_inc[LIN_W-1:0];
                if (32'(wr_addr_reg) == LS_DEPTH - 1)
                    wr_addr_next = '0;
                else
                    wr_addr_next = wr_addr_reg + 1'b1;
            end
            if (go)
            begin
                oc_next   = out_col_reg;
                orow_next = out_row_reg;
                done_next = last_out;
                if (last_out)
                begin
                    in_lin_next   = '0;
                    wr_addr_next  = '0;
                    out_lin_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_base_next = '0;
                end
                else
                begin
                    out_lin_next = out_lin_reg + 1'b1;
                    if (32'(out_base_reg) == LS_DEPTH - 1)
                        out_base_next = '0;
                    else
                        out_base_next = out_base_reg + 1'b1;
                    if (out_col_reg + 1'b1 >= w_eff)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // scan, accumulate and divide
    always_comb
    begin
        a_next          = a_reg;
        b_next          = b_reg;
        rd_addr_next    = rd_addr_reg;
        pend_valid_next = (state_reg == cbb_pkg::ST_SCAN);
        pend_inb_next   = inb;
        cnt_next        = cnt_reg;
        div_cnt_next    = div_cnt_reg;
        divisor         = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = sum_reg[k];
            rem_next[k] = rem_reg[k];
            rem_t[k]    = {rem_reg[k], sum_reg[k][SUM_W-1]};
        end
        if (acc && go)
        begin
            a_next       = '0;
            b_next       = '0;
            rd_addr_next = AW'(start_addr);
            cnt_next     = '0;
            for (int k = 0; k < 3; k++)
                sum_next[k] = '0;
        end
        if (state_reg == cbb_pkg::ST_SCAN)
        begin
            rd_addr_next = AW'(stepped);
            if (b_reg == two_r)
            begin
                b_next = '0;
                a_next = a_reg + 1'b1;
            end
            else
            begin
                b_next = b_reg + 1'b1;
            end
        end
        if (pend_valid_reg && pend_inb_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            for (int k = 0; k < 3; k++)
                sum_next[k] = sum_reg[k] + SUM_W'(rdata[k*CH_W +: CH_W]);
        end
        if (state_reg == cbb_pkg::ST_WAIT)
        begin
            div_cnt_next = '0;
            for (int k = 0; k < 3; k++)
                rem_next[k] = '0;
        end
        if (state_reg == cbb_pkg::ST_DIV)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if (rem_t[k] >= {1'b0, divisor})
                begin
                    rem_next[k] = CNT_W'(rem_t[k] - {1'b0, divisor});
                    sum_next[k] = {sum_reg[k][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = rem_t[k][CNT_W-1:0];
                    sum_next[k] = {sum_reg[k][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (state_reg == cbb_pkg::ST_EMIT && out_free)
        begin
            m_valid_next = 1'b1;
            m_last_next  = done_reg;
            m_data_next  = {4'b0000,
                            cbb_pkg::OUT_POS_W'(orow_reg),
                            cbb_pkg::OUT_POS_W'(oc_reg),
                            sum_reg[2][CH_W-1:0],
                            sum_reg[1][CH_W-1:0],
                            sum_reg[0][CH_W-1:0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cbb_pkg::ST_IDLE;
            width_reg      <= cbb_pkg::IMAGE_WIDTH_RST;
            height_reg     <= cbb_pkg::IMAGE_HEIGHT_RST;
            radius_reg     <= cbb_pkg::RADIUS_RST;
            in_lin_reg     <= '0;
            wr_addr_reg    <= '0;
            out_lin_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_base_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            radius_reg     <= radius_next;
            in_lin_reg     <= in_lin_next;
            wr_addr_reg    <= wr_addr_next;
            out_lin_reg    <= out_lin_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            out_base_reg   <= out_base_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        oc_reg       <= oc_next;
        orow_reg     <= orow_next;
        done_reg     <= done_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        rd_addr_reg  <= rd_addr_next;
        pend_inb_reg <= pend_inb_next;
        cnt_reg      <= cnt_next;
        div_cnt_reg  <= div_cnt_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        for (int k = 0; k < 3; k++)
        begin
            sum_reg[k] <= sum_next[k];
            rem_reg[k] <= rem_next[k];
        end
    end

    // pixel ring
    cbb_ram #(
        .WIDTH (cbb_pkg::PIX_W),
        .DEPTH (LS_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (acc && is_pix),
        .waddr (wr_addr_reg),
        .wdata (s_tdata),
        .re    (state_reg == cbb_pkg::ST_SCAN),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

endmodule
`default_nettype wire

// ===== dv/tb_clipped_box_blur_top.sv =====
// self-checking testbench for the clipped box blur stream block
`timescale 1ns / 1ps
module tb_clipped_box_blur_top;

    localparam bit OP_PIXEL = 1'b0;
    localparam bit OP_DRAIN = 1'b1;
    localparam int HIST_DEPTH =
        2 * cbb_pkg::MAX_RADIUS_DEF * (cbb_pkg::MAX_WIDTH_DEF + 1) + 1;
    localparam int SETTLE_CYCLES = 4 + 15 * 15 + 16 + 20;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_TARGET = 1450;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } blur_px_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [cbb_pkg::CFG_IDX_W-1:0]  idx;
        logic [cbb_pkg::CFG_DATA_W-1:0] val;
        bit                             op;
        logic [23:0]                    pix;
        bit                             has_exp;
        blur_px_t                       exp_px;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cbb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cbb_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cbb_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cbb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    // predictor state
    logic [23:0] hist [HIST_DEPTH];
    int unsigned width_raw, height_raw, radius_raw;
    int unsigned in_col, in_row, out_col, out_row;

    blur_px_t pending_px [$];
    stim_row_t stim_tab [$];
    int  mismatches;
    int  item_count;
    int  idle_cycles;
    bit  calm;
    int  rx_stall;

    clipped_box_blur_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
        if (v == 0)
            return 1;
        return (v > mx) ? mx : v;
    endfunction

    // frame restart on any register write
    function automatic void restart_positions();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // append an expected pixel to the scoreboard
    function automatic void queue_px(blur_px_t px);
        pending_px.insert(pending_px.size(), px);
    endfunction

    // append one row to the stimulus table
    function automatic void add_row(row_kind_t kind, logic [cbb_pkg::CFG_IDX_W-1:0] idx,
                                    logic [cbb_pkg::CFG_DATA_W-1:0] val, bit op,
                                    logic [23:0] pix, bit has_exp, blur_px_t exp_px);
        stim_row_t row;
        row.kind = kind;
        row.idx = idx;
        row.val = val;
        row.op = op;
        row.pix = pix;
        row.has_exp = has_exp;
        row.exp_px = exp_px;
        stim_tab.insert(stim_tab.size(), row);
    endfunction

    // one step of the blur: returns 1 when the item yields an output pixel
    function automatic bit blur_step(bit op, logic [23:0] pix, output blur_px_t res);
        int unsigned w, h, r, total, lag, in_lin, out_lin, cnt;
        int unsigned sr, sg, sb;
        int i, j;
        bit emit;
        w = clamp_dim(width_raw, cbb_pkg::MAX_WIDTH_DEF);
        h = clamp_dim(height_raw, cbb_pkg::MAX_HEIGHT_DEF);
        r = (radius_raw > cbb_pkg::MAX_RADIUS_DEF) ? cbb_pkg::MAX_RADIUS_DEF : radius_raw;
        total = w * h;
        lag = r * w + r;
        in_lin = in_row * w + in_col;
        out_lin = out_row * w + out_col;
        res = '0;
        if (op == OP_PIXEL && in_lin < total)
        begin
            hist[in_lin % HIST_DEPTH] = pix;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            in_lin++;
            emit = (out_lin + lag < in_lin);
        end
        else
            emit = (in_lin >= total);
        if (!emit || out_lin >= total)
            return 0;
        sr = 0;
        sg = 0;
        sb = 0;
        cnt = 0;
        // clipped window sums
        for (j = int'(out_row) - int'(r); j <= int'(out_row) + int'(r); j++)
        begin
            if (j < 0 || j >= int'(h))
                continue;
            for (i = int'(out_col) - int'(r); i <= int'(out_col) + int'(r); i++)
            begin
                if (i < 0 || i >= int'(w))
                    continue;
                sr += hist[(j * w + i) % HIST_DEPTH][7:0];
                sg += hist[(j * w + i) % HIST_DEPTH][15:8];
                sb += hist[(j * w + i) % HIST_DEPTH][23:16];
                cnt++;
            end
        end
        if (cnt == 0)
            cnt = 1;
        res.red = 8'(sr / cnt);
        res.green = 8'(sg / cnt);
        res.blue = 8'(sb / cnt);
        res.col = 10'(out_col);
        res.row = 10'(out_row);
        if (out_lin + 1 >= total)
        begin
            res.last = 1'b1;
            restart_positions();
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void report_mismatch(string what, blur_px_t want, blur_px_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch (%s): exp r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
                     what, want.red, want.green, want.blue, want.col, want.row, want.last);
            $display("    got r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
                     got.red, got.green, got.blue, got.col, got.row, got.last);
        end
    endfunction

    // send one item, update the predictor at acceptance
    task automatic send_item(bit op, logic [23:0] pix, bit has_exp, blur_px_t exp_px);
        int gap;
        blur_px_t res;
        bit got;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        got = blur_step(op, pix, res);
        if (has_exp)
        begin
            if (!got || res != exp_px)
                report_mismatch("predictor vs table", exp_px, res);
            queue_px(exp_px);
        end
        else if (got)
            queue_px(res);
    endtask

    // pause the sender until every expected pixel has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [cbb_pkg::CFG_IDX_W-1:0] idx,
                             logic [cbb_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cbb_pkg::REG_IMAGE_WIDTH:  width_raw = val;
            cbb_pkg::REG_IMAGE_HEIGHT: height_raw = val;
            cbb_pkg::REG_RADIUS:       radius_raw = val[cbb_pkg::RAD_CFG_W-1:0];
            default: ;
        endcase
        restart_positions();
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // one frame with random content, optionally cut short
    task automatic run_frame(int unsigned w_raw, int unsigned h_raw, int unsigned r_raw,
                             int npix_req);
        int unsigned w, h;
        int npix;
        blur_px_t none;
        none = '0;
        write_reg(cbb_pkg::REG_IMAGE_WIDTH, 11'(w_raw));
        write_reg(cbb_pkg::REG_IMAGE_HEIGHT, 11'(h_raw));
        write_reg(cbb_pkg::REG_RADIUS, 11'(r_raw));
        calm = ($urandom_range(0, 3) == 0);
        w = clamp_dim(w_raw, cbb_pkg::MAX_WIDTH_DEF);
        h = clamp_dim(h_raw, cbb_pkg::MAX_HEIGHT_DEF);
        npix = (npix_req < 0) ? int'(w * h) : npix_req;
        for (int k = 0; k < npix; k++)
        begin
            // stray drain before frame end is ignored
            if ($urandom_range(0, 99) < 3 && k > 0)
                send_item(OP_DRAIN, 24'($urandom), 1'b0, none);
            if ($urandom_range(0, 199) == 0)
                wait_drained();
            send_item(OP_PIXEL, rand_pixel(), 1'b0, none);
            item_count++;
        end
        if (npix == int'(w * h))
        begin
            // flush, sometimes with surplus pixels acting as drains
            while (in_col != 0 || in_row != 0)
            begin
                send_item($urandom_range(0, 4) == 0 ? OP_PIXEL : OP_DRAIN,
                          24'($urandom), 1'b0, none);
                item_count++;
            end
        end
    endtask

    // receiver: random stalls and checking
    always @(posedge clk)
    begin
        blur_px_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                       m_tdata[33:24], m_tdata[43:34], m_tlast};
                if (pending_px.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output pixel col=%0d row=%0d",
                                 got.col, got.row);
                end
                else
                begin
                    want = pending_px.pop_front();
                    if (got != want)
                        report_mismatch("output", want, got);
                end
            end
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    rx_stall = pick_gap();
            end
        end
    end

    // watchdog on cycles without any handshake on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        blur_px_t none;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        item_count = 0;
        idle_cycles = 0;
        rx_stall = 0;
        calm = 1'b0;
        width_raw = cbb_pkg::IMAGE_WIDTH_RST;
        height_raw = cbb_pkg::IMAGE_HEIGHT_RST;
        radius_raw = cbb_pkg::RADIUS_RST;
        restart_positions();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sizes act as 1x1; radius 7 means the only output waits for a drain
        add_row(ROW_CFG, cbb_pkg::REG_IMAGE_WIDTH, 11'd0, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_CFG, cbb_pkg::REG_IMAGE_HEIGHT, 11'd0, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_CFG, cbb_pkg::REG_RADIUS, 11'd7, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'h3264c8, 0, none);
        // pixel after the last input acts as a drain
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'h030201, 1,
                '{8'd200, 8'd100, 8'd50, 10'd0, 10'd0, 1'b1});
        // drain early in a frame is ignored
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_DRAIN, 24'hffffff, 0, none);
        // radius 0: output equals input, red and green at both extremes
        add_row(ROW_CFG, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'haa00ff, 1,
                '{8'd255, 8'd0, 8'd170, 10'd0, 10'd0, 1'b1});
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'h55ff00, 1,
                '{8'd0, 8'd255, 8'd85, 10'd0, 10'd0, 1'b1});
        // 2x2 with radius 1: every window covers the frame, truncated mean
        add_row(ROW_CFG, cbb_pkg::REG_IMAGE_WIDTH, 11'd2, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_CFG, cbb_pkg::REG_IMAGE_HEIGHT, 11'd2, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_CFG, cbb_pkg::REG_RADIUS, 11'd1, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'h0000ff, 0, none);
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'hff00ff, 0, none);
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'hff00ff, 0, none);
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL, 24'hff03ff, 1,
                '{8'd255, 8'd0, 8'd191, 10'd0, 10'd0, 1'b0});
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_DRAIN, 24'h0, 1,
                '{8'd255, 8'd0, 8'd191, 10'd1, 10'd0, 1'b0});
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_DRAIN, 24'h0, 1,
                '{8'd255, 8'd0, 8'd191, 10'd0, 10'd1, 1'b0});
        add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_DRAIN, 24'h0, 1,
                '{8'd255, 8'd0, 8'd191, 10'd1, 10'd1, 1'b1});
        // 3x2 radius 2, checked by the predictor
        add_row(ROW_CFG, cbb_pkg::REG_IMAGE_WIDTH, 11'd3, OP_PIXEL, 24'h0, 0, none);
        add_row(ROW_CFG, cbb_pkg::REG_RADIUS, 11'd2, OP_PIXEL, 24'h0, 0, none);
        for (int k = 0; k < 6; k++)
            add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_PIXEL,
                    24'(k * 24'h2a1307), 0, none);
        for (int k = 0; k < 6; k++)
            add_row(ROW_ITEM, cbb_pkg::REG_RADIUS, 11'd0, OP_DRAIN, 24'h0, 0, none);

        foreach (stim_tab[n])
        begin
            if (stim_tab[n].kind == ROW_CFG)
                write_reg(stim_tab[n].idx, stim_tab[n].val);
            else
            begin
                send_item(stim_tab[n].op, stim_tab[n].pix, stim_tab[n].has_exp,
                          stim_tab[n].exp_px);
                item_count++;
            end
        end

        // saturated width and the tallest height, partial frames
        run_frame(2047, 1, 7, 40);
        run_frame(1, 1024, 7, 40);

        // random frames, mostly complete, a few cut short
        while (item_count < ITEM_TARGET)
        begin
            int unsigned wr, hr;
            case ($urandom_range(0, 9))
                0: wr = 0;
                1: wr = $urandom_range(13, 40);
                default: wr = $urandom_range(1, 12);
            endcase
            hr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
                run_frame(wr, hr, $urandom_range(0, 7),
                          $urandom_range(0, clamp_dim(wr, 1024) * clamp_dim(hr, 1024) - 1));
            else
                run_frame(wr, hr, $urandom_range(0, 7), -1);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_px.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
